[src/wris_pkg.sv]
// Package with the shared types, codes and constants of the weighted index selector.
package wris_pkg;

  localparam int DATA_W = 64;
  localparam int WEIGHT_W = 62;
  localparam int INDEX_W = 8;
  localparam int STATUS_W = 3;
  localparam int STEP_W = $clog2(DATA_W);
  localparam int DEFAULT_MAX_ENTRIES = 256;

  localparam logic [DATA_W-1:0] LIMIT_TOTAL = {1'b0, {(DATA_W-1){1'b1}}};

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_PICK = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_WEIGHTED = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNIFORM = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED = 3'd4;

  typedef struct packed {
    logic valid;
    logic [DATA_W-1:0] sum;
  } cell_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN
  } state_t;

endpackage

[src/wris_cell.sv]
// One cell of the prefix sum chain, holding one stored sum and its valid flag.
module wris_cell
  import wris_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  cell_t din,
  output cell_t dout
);

  logic valid;
  logic [DATA_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      sum <= din.sum;
    end
  end

  assign dout.valid = valid;
  assign dout.sum = sum;

endmodule

[src/wris_mod_unit.sv]
// Iterative restoring modulo unit that retires one dividend bit per cycle.
module wris_mod_unit
  import wris_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] remainder
);

  logic active;
  logic [STEP_W-1:0] step_cnt;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W-1:0] rem;
  logic [DATA_W:0] trial;
  logic [DATA_W:0] diff;
  logic fits;
  logic [DATA_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dvd[DATA_W-1]};
    diff = trial - {1'b0, dvs};
    fits = (trial >= {1'b0, dvs});
    rem_next = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= !start && active && (step_cnt == STEP_W'(DATA_W - 1));
      if (start) begin
        active <= 1'b1;
        step_cnt <= '0;
      end else if (active) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == STEP_W'(DATA_W - 1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (active) begin
      dvd <= {dvd[DATA_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

[src/weighted_random_index_select.sv]
// Top level of the weighted random index selector with its control and cell chain.
// An add word leaves the selector idle, so the next word may follow in the next cycle.
// A pick word first runs the one-bit-per-cycle modulo unit, then shifts the cell chain
// through one whole pass, so that every stored cell moves out past its tail.
// The result is shown for one cycle with done high; the receiver cannot stall it.
// Synchronous reset empties the set and clears all control state.
module weighted_random_index_select
  import wris_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [DATA_W-1:0]   random_word,
  output logic                done,
  output logic [INDEX_W-1:0]  index,
  output logic [STATUS_W-1:0] status
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SCAN_W = $clog2(MAX_ENTRIES);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0] count;
  logic [DATA_W-1:0] total;
  logic ovf;
  logic drop;
  logic [STATUS_W-1:0] status_q;
  logic [DATA_W-1:0] draw;
  logic [SCAN_W-1:0] scan_cnt;
  logic [CNT_W-1:0] hits;
  logic [CNT_W-1:0] hits_next;

  logic [DATA_W-1:0] sum_add;
  logic sat;
  logic [DATA_W-1:0] new_sum;
  logic full;
  logic [STATUS_W-1:0] pick_status;
  logic [DATA_W-1:0] div_divisor;
  logic div_start;
  logic div_done;
  logic [DATA_W-1:0] div_rem;
  logic add_go;
  logic pick_go;
  logic scan_last;
  logic tail_hit;
  logic shift;
  cell_t head_in;
  cell_t chain [MAX_ENTRIES];

  genvar k;
  generate
    for (k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      if (k == 0) begin : g_head
        wris_cell u_cell (
          .clk  (clk),
          .rst  (rst),
          .shift(shift),
          .din  (head_in),
          .dout (chain[k])
        );
      end else begin : g_body
        wris_cell u_cell (
          .clk  (clk),
          .rst  (rst),
          .shift(shift),
          .din  (chain[k-1]),
          .dout (chain[k])
        );
      end
    end
  endgenerate

  wris_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (random_word),
    .divisor  (div_divisor),
    .done     (div_done),
    .remainder(div_rem)
  );

  always_comb begin
    sum_add = total + {{(DATA_W-WEIGHT_W){1'b0}}, weight};
    sat = (sum_add >= LIMIT_TOTAL);
    new_sum = sat ? LIMIT_TOTAL : sum_add;
    full = (count == CNT_W'(MAX_ENTRIES));
    div_divisor = (total == '0) ? DATA_W'(count) : total;
    if (count == '0) begin
      pick_status = STATUS_EMPTY;
    end else if (drop) begin
      pick_status = STATUS_DROPPED;
    end else if (ovf) begin
      pick_status = STATUS_TOO_LARGE;
    end else if (total == '0) begin
      pick_status = STATUS_UNIFORM;
    end else begin
      pick_status = STATUS_WEIGHTED;
    end
    tail_hit = chain[MAX_ENTRIES-1].valid && (chain[MAX_ENTRIES-1].sum <= draw);
    hits_next = hits + CNT_W'(tail_hit);
    scan_last = (scan_cnt == SCAN_W'(MAX_ENTRIES - 1));
  end

  always_comb begin
    state_next = state;
    shift = 1'b0;
    head_in.valid = 1'b0;
    head_in.sum = new_sum;
    div_start = 1'b0;
    add_go = 1'b0;
    pick_go = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (op == OP_ADD) begin
            add_go = 1'b1;
            if (!full) begin
              shift = 1'b1;
              head_in.valid = 1'b1;
            end
          end else begin
            pick_go = 1'b1;
            div_start = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift = 1'b1;
        if (scan_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      total <= '0;
      ovf <= 1'b0;
      drop <= 1'b0;
      done <= 1'b0;
      scan_cnt <= '0;
      hits <= '0;
    end else begin
      state <= state_next;
      done <= (state == ST_SCAN) && scan_last;
      if (add_go) begin
        if (full) begin
          drop <= 1'b1;
        end else begin
          count <= count + 1'b1;
          total <= new_sum;
          ovf <= ovf | sat;
        end
      end
      if (pick_go) begin
        count <= '0;
        total <= '0;
        ovf <= 1'b0;
        drop <= 1'b0;
        scan_cnt <= '0;
        hits <= '0;
      end
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
        hits <= hits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pick_go) begin
      status_q <= pick_status;
    end
    if (state == ST_DIV && div_done) begin
      draw <= div_rem;
    end
    if (state == ST_SCAN && scan_last) begin
      status <= status_q;
      if (status_q == STATUS_WEIGHTED) begin
        index <= INDEX_W'(hits_next);
      end else if (status_q == STATUS_UNIFORM) begin
        index <= INDEX_W'(draw);
      end else begin
        index <= '0;
      end
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

[dv/weighted_random_index_select_test.sv]
// Self-checking testbench for the weighted random index selector with a scoreboard.
`timescale 1ns / 1ps

module weighted_random_index_select_test;
  import wris_pkg::*;

  localparam int MAX_ENTRIES = DEFAULT_MAX_ENTRIES;
  localparam int WORD_TARGET = 1450;
  localparam int IDLE_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;
  localparam logic [WEIGHT_W-1:0] MAX_WEIGHT = {WEIGHT_W{1'b1}};

  typedef struct packed {
    logic [INDEX_W-1:0]  sel_index;
    logic [STATUS_W-1:0] sel_status;
  } pick_result_t;

  class pick_scoreboard;
    logic [DATA_W-1:0] sums [MAX_ENTRIES];
    int                count;
    logic [DATA_W-1:0] total;
    bit                overflow;
    bit                dropped;
    pick_result_t      pending_picks [$];
    int                errors;
    int                words_seen;
    int                picks_seen;
    int                outcome_seen [5];

    function new();
      errors = 0;
      words_seen = 0;
      picks_seen = 0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
      clear_set();
    endfunction

    function void clear_set();
      count = 0;
      total = '0;
      overflow = 1'b0;
      dropped = 1'b0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    function void note_word(logic word_op, logic [WEIGHT_W-1:0] w, logic [DATA_W-1:0] word);
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] draw;
      logic [DATA_W-1:0] uniform_pos;
      pick_result_t res;
      bit found;
      words_seen++;
      if (word_op == OP_ADD) begin
        if (count >= MAX_ENTRIES) begin
          dropped = 1'b1;
        end else begin
          sum = total + {{(DATA_W-WEIGHT_W){1'b0}}, w};
          if (sum >= LIMIT_TOTAL) begin
            sum = LIMIT_TOTAL;
            overflow = 1'b1;
          end
          total = sum;
          sums[count] = sum;
          count++;
        end
      end else begin
        res.sel_index = '0;
        found = 1'b0;
        if (count == 0) begin
          res.sel_status = STATUS_EMPTY;
        end else if (dropped) begin
          res.sel_status = STATUS_DROPPED;
        end else if (overflow) begin
          res.sel_status = STATUS_TOO_LARGE;
        end else if (total == '0) begin
          uniform_pos = word % DATA_W'(count);
          res.sel_index = uniform_pos[INDEX_W-1:0];
          res.sel_status = STATUS_UNIFORM;
        end else begin
          draw = word % total;
          for (int i = 0; i < count; i++) begin
            if (sums[i] > draw && !found) begin
              res.sel_index = INDEX_W'(i);
              found = 1'b1;
            end
          end
          res.sel_status = STATUS_WEIGHTED;
        end
        outcome_seen[res.sel_status]++;
        pending_picks.push_back(res);
        clear_set();
      end
    endfunction

    function void check_result(logic [INDEX_W-1:0] got_index, logic [STATUS_W-1:0] got_status);
      pick_result_t want;
      if (pending_picks.size() == 0) begin
        flag($sformatf("result with none expected: index %0d status %0d", got_index, got_status));
        return;
      end
      want = pending_picks.pop_front();
      picks_seen++;
      if (got_status !== want.sel_status) begin
        flag($sformatf("pick %0d status: expected %0d, got %0d",
                       picks_seen, want.sel_status, got_status));
      end
      if (got_index !== want.sel_index) begin
        flag($sformatf("pick %0d index: expected %0d, got %0d",
                       picks_seen, want.sel_index, got_index));
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic                op;
  logic [WEIGHT_W-1:0] weight;
  logic [DATA_W-1:0]   random_word;
  logic                done;
  logic [INDEX_W-1:0]  index;
  logic [STATUS_W-1:0] status;

  pick_scoreboard sb;
  int words_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  weighted_random_index_select #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .weight(weight),
    .random_word(random_word),
    .done(done),
    .index(index),
    .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(index, status);
      if (start && !busy) sb.note_word(op, weight, random_word);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out with no word moving for %0d cycles.", IDLE_LIMIT);
      $display("FAIL weighted_random_index_select");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [DATA_W-1:0] random_bits();
    logic [DATA_W-1:0] bits;
    bits = {$urandom(), $urandom()};
    return bits;
  endfunction

  function automatic logic [DATA_W-1:0] random_draw_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return random_bits();
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] random_weight(int mode);
    logic [DATA_W-1:0] bits;
    bits = random_bits();
    case (mode)
      0: return '0;
      1: return WEIGHT_W'($urandom_range(0, 15));
      2: return bits[WEIGHT_W-1:0];
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return MAX_WEIGHT;
          2: return WEIGHT_W'($urandom_range(0, 15));
          default: return bits[WEIGHT_W-1:0];
        endcase
      end
    endcase
  endfunction

  task automatic send_word(input logic word_op, input logic [WEIGHT_W-1:0] w,
                           input logic [DATA_W-1:0] word);
    start <= 1'b1;
    op <= word_op;
    weight <= w;
    random_word <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 30);
    end
  endtask

  initial begin
    int choice;
    int adds;
    int mode;
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    op <= OP_ADD;
    weight <= '0;
    random_word <= '0;
    burst_left = $urandom_range(1, 30);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed words: empty set, all-zero weights, too large a total,
    // the largest weight with draws on the boundaries, and zero-weight entries.
    send_word(OP_PICK, '0, '0);
    repeat (3) send_word(OP_ADD, '0, '1);
    send_word(OP_PICK, MAX_WEIGHT, '1);
    repeat (3) send_word(OP_ADD, MAX_WEIGHT, '0);
    send_word(OP_PICK, '0, random_bits());
    send_word(OP_ADD, MAX_WEIGHT, '0);
    send_word(OP_ADD, '0, '0);
    send_word(OP_ADD, WEIGHT_W'(1), '0);
    send_word(OP_PICK, '0, {{(DATA_W-WEIGHT_W){1'b0}}, MAX_WEIGHT});
    send_word(OP_ADD, WEIGHT_W'(1), '0);
    send_word(OP_PICK, '0, random_bits());
    send_word(OP_ADD, '0, '0);
    send_word(OP_ADD, WEIGHT_W'(5), '0);
    send_word(OP_PICK, '0, '0);

    while (words_sent < WORD_TARGET) begin
      choice = $urandom_range(0, 99);
      if (choice < 6) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(logic'($urandom_range(0, 1)), random_weight(2), random_bits());
        end
      end else begin
        if (choice < 10) adds = $urandom_range(MAX_ENTRIES - 6, MAX_ENTRIES + 6);
        else if (choice < 14) adds = 0;
        else adds = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          0: mode = 0;
          1, 2, 3, 4: mode = 1;
          5, 6, 7: mode = 2;
          default: mode = 3;
        endcase
        repeat (adds) send_word(OP_ADD, random_weight(mode), random_bits());
        send_word(OP_PICK, random_weight(2), random_draw_word());
      end
    end

    start <= 1'b0;
    while (sb.pending_picks.size() != 0) @(posedge clk);
    repeat (MAX_ENTRIES + 80) @(posedge clk);

    $display("Covered %0d words and %0d picks; outcomes weighted %0d, uniform %0d, empty %0d,",
             sb.words_seen, sb.picks_seen, sb.outcome_seen[STATUS_WEIGHTED],
             sb.outcome_seen[STATUS_UNIFORM], sb.outcome_seen[STATUS_EMPTY]);
    $display("too large %0d, dropped %0d; %0d mismatches.",
             sb.outcome_seen[STATUS_TOO_LARGE], sb.outcome_seen[STATUS_DROPPED], sb.errors);
    if (sb.errors == 0) begin
      $display("PASS weighted_random_index_select");
    end else begin
      $display("FAIL weighted_random_index_select");
    end
    $finish;
  end

endmodule

[weighted_random_index_select.f]
src/wris_pkg.sv
src/wris_cell.sv
src/wris_mod_unit.sv
src/weighted_random_index_select.sv
dv/weighted_random_index_select_test.sv
